[sv/rdfqtbf_pkg.sv]
// Shared types and character constants for the N-Quads term boundary finder.
`timescale 1ns / 1ps
`default_nettype none

package rdfqtbf_pkg;

  // Characters that steer the term search
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'
  localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash

  localparam int unsigned SLOT_BITS = 3;
  localparam int unsigned POS_OUT_BITS = 16;

  // Entries in the queue between the front and the back
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IRI   = 3'd1,
    MODE_LIT   = 3'd2,
    MODE_BLANK = 3'd3,
    MODE_QUAL  = 3'd4
  } mode_e;

  // One request: a character of the line
  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } req_t;

  // One result: a term boundary
  typedef struct packed {
    logic [SLOT_BITS-1:0]    slot;
    logic [POS_OUT_BITS-1:0] position;
    logic                    last_of_run;
  } res_t;

  // All boundaries caused by one request (one or two)
  typedef struct packed {
    logic                    two;
    logic [SLOT_BITS-1:0]    slot0;
    logic [POS_OUT_BITS-1:0] pos0;
    logic [SLOT_BITS-1:0]    slot1;
    logic [POS_OUT_BITS-1:0] pos1;
  } qent_t;

endpackage

`default_nettype wire

[sv/rdfqtbf_front.sv]
// Front end: takes characters, tracks the search mode and finds boundaries.
`timescale 1ns / 1ps
`default_nettype none

module rdfqtbf_front import rdfqtbf_pkg::*; #(
  parameter int unsigned MAX_SLOTS     = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire req_t  req_i,
  output logic       q_push_o,
  output qent_t      q_data_o
);

  localparam int unsigned PW = POSITION_BITS;
  localparam int unsigned SW = $clog2(MAX_SLOTS + 1);

  typedef struct packed {
    mode_e         mode;
    logic          par;
    logic          hit;
    logic [PW-1:0] pos;
  } jres_t;

  mode_e         mode_q, mode_d;
  logic [7:0]    held_q, held_d;
  logic          held_valid_q, held_valid_d;
  logic          par_q, par_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [PW-1:0] pos_q, pos_d;

  jres_t         j0, j1;
  mode_e         m1;
  logic          p1;
  logic          e0, e1;
  logic [SW-1:0] s1;
  logic [PW-1:0] prev;

  function automatic logic [PW-1:0] end_before(logic [PW-1:0] pos);
    return (pos == '0) ? '0 : pos - PW'(1);
  endfunction

  function automatic logic [POS_OUT_BITS-1:0] to_out(logic [PW-1:0] pos);
    logic [PW+POS_OUT_BITS-1:0] wide;
    wide = {{POS_OUT_BITS{1'b0}}, pos};
    return wide[POS_OUT_BITS-1:0];
  endfunction

  // Judge one character against the mode, given whether its successor is a space
  function automatic jres_t judge(mode_e m, logic par, logic [7:0] c, logic nsp,
                                  logic [PW-1:0] pos);
    jres_t r;
    r.mode = m;
    r.hit  = 1'b0;
    r.pos  = pos;
    unique case (m)
      MODE_IDLE: begin
        if (c == CH_LT) begin
          r.hit = 1'b1; r.mode = MODE_IRI;
        end else if (c == CH_QUOTE) begin
          r.hit = 1'b1; r.mode = MODE_LIT;
        end else if (c == CH_UNDER) begin
          r.hit = 1'b1; r.mode = MODE_BLANK;
        end
      end
      MODE_IRI: begin
        if (c == CH_GT && nsp) begin
          r.hit = 1'b1; r.mode = MODE_IDLE;
        end
      end
      MODE_BLANK, MODE_QUAL: begin
        if (c == CH_SPACE) begin
          r.hit = 1'b1; r.mode = MODE_IDLE; r.pos = end_before(pos);
        end
      end
      MODE_LIT: begin
        if (c == CH_QUOTE && !par) begin
          if (nsp) begin
            r.hit = 1'b1; r.mode = MODE_IDLE;
          end else begin
            r.mode = MODE_QUAL;
          end
        end
      end
      default: r.mode = MODE_IDLE;
    endcase
    r.par = (c == CH_BSL) ? ~par : 1'b0;
    return r;
  endfunction

  always_comb begin
    prev = pos_q - PW'(1);
    // Held character, judged with the incoming one as lookahead
    j0 = judge(mode_q, par_q, held_q, req_i.char_code == CH_SPACE, prev);
    m1 = held_valid_q ? j0.mode : mode_q;
    p1 = held_valid_q ? j0.par : par_q;
    // Incoming character on a line end, lookahead counts as not a space
    j1 = judge(m1, p1, req_i.char_code, 1'b0, pos_q);

    e0 = held_valid_q && j0.hit && (slot_q < SW'(MAX_SLOTS));
    s1 = slot_q + SW'(e0);
    e1 = req_i.line_end && j1.hit && (s1 < SW'(MAX_SLOTS));

    q_push_o       = accept_i && (e0 || e1);
    q_data_o.two   = e0 && e1;
    q_data_o.slot0 = slot_q[SLOT_BITS-1:0];
    q_data_o.pos0  = e0 ? to_out(j0.pos) : to_out(j1.pos);
    q_data_o.slot1 = s1[SLOT_BITS-1:0];
    q_data_o.pos1  = to_out(j1.pos);
  end

  always_comb begin
    mode_d       = mode_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    par_d        = par_q;
    slot_d       = slot_q;
    pos_d        = pos_q;
    if (accept_i) begin
      if (req_i.line_end) begin
        // Clear everything for the next line
        mode_d       = MODE_IDLE;
        held_d       = '0;
        held_valid_d = 1'b0;
        par_d        = 1'b0;
        slot_d       = '0;
        pos_d        = '0;
      end else begin
        mode_d       = m1;
        par_d        = p1;
        held_d       = req_i.char_code;
        held_valid_d = 1'b1;
        slot_d       = s1;
        pos_d        = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      par_q        <= 1'b0;
      slot_q       <= '0;
      pos_q        <= '0;
    end else begin
      mode_q       <= mode_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      par_q        <= par_d;
      slot_q       <= slot_d;
      pos_q        <= pos_d;
    end
  end

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SW'(MAX_SLOTS))
    else $error("slot count beyond limit");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && req_i.line_end |=> !held_valid_q && slot_q == '0 && pos_q == '0)
    else $error("state not cleared after line end");

  a_two_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && q_data_o.two |-> held_valid_q && req_i.line_end)
    else $error("two boundaries without held character and line end");

endmodule

`default_nettype wire

[sv/rdfqtbf_queue.sv]
// Short queue of boundary groups between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module rdfqtbf_queue import rdfqtbf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output qent_t      data_o,
  output logic       empty_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  qent_t         mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? ((wp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + AW'(1)) : wp_q;
    rp_d  = do_pop ? ((rp_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + AW'(1)) : rp_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

[sv/rdfqtbf_back.sv]
// Back end: splits boundary groups into single results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module rdfqtbf_back import rdfqtbf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_empty_i,
  input  wire qent_t q_data_i,
  output logic       q_pop_o,
  output logic       empty_o,
  input  wire logic  pop_i,
  output res_t       res_o
);

  logic  valid_q, valid_d;
  qent_t ent_q, ent_d;
  logic  sel_q, sel_d;
  logic  last_part, taken;

  assign last_part = sel_q || !ent_q.two;
  assign taken     = valid_q && pop_i;
  assign q_pop_o   = !q_empty_i && (!valid_q || (taken && last_part));
  assign empty_o   = !valid_q;

  always_comb begin
    res_o.slot        = sel_q ? ent_q.slot1 : ent_q.slot0;
    res_o.position    = sel_q ? ent_q.pos1 : ent_q.pos0;
    res_o.last_of_run = last_part;
  end

  always_comb begin
    valid_d = valid_q;
    ent_d   = ent_q;
    sel_d   = sel_q;
    if (taken && !last_part) begin
      // Advance to the second boundary of the group
      sel_d = 1'b1;
    end else if (!valid_q || taken) begin
      valid_d = q_pop_o;
      sel_d   = 1'b0;
      if (q_pop_o) begin
        ent_d = q_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sel_q   <= sel_d;
    end
  end

  a_sel_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && sel_q |-> ent_q.two)
    else $error("second boundary selected in single group");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> !q_empty_i)
    else $error("back pops empty queue");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken && !last_part |=> valid_q && sel_q)
    else $error("second boundary not presented");

endmodule

`default_nettype wire

[sv/rdf_quad_term_boundary_finder.sv]
// A boundary passes from the front through the queue into the back end's output register before it shows on res_o.
// Throughput: one request per cycle while the queue is not full; results leave
//   one per cycle while pop_i is high, the two boundaries of a request in turn.
// full_o rises only when the four-group queue between front and back is full.
// Reset (rst_ni low, asynchronous) clears search mode, hold, counters and queue.
`timescale 1ns / 1ps
`default_nettype none

module rdf_quad_term_boundary_finder import rdfqtbf_pkg::*; #(
  parameter int unsigned MAX_SLOTS     = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // Request side: one character of the line
  input  wire logic push_i,
  output logic      full_o,
  input  wire req_t req_i,
  // Result side: one term boundary
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      res_o
);

  // Queue handshake between the front and the back
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_wdata, q_rdata;
  logic  accept;

  // Accept whenever the queue has room; a request with no boundary still goes in
  assign full_o = q_full;
  assign accept = push_i && !q_full;

  // Front: judge each held character against its lookahead, number boundaries
  rdfqtbf_front #(
    .MAX_SLOTS    (MAX_SLOTS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  // Queue: hold groups of one or two boundaries so each side stalls on its own
  rdfqtbf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  // Back: present boundaries one at a time from an output register
  rdfqtbf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .empty_o  (empty_o),
    .pop_i    (pop_i),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire
